>>> rtl/core/wbem_pkg.sv
`default_nettype none

package wbem_pkg;

   // Gate count and the fixed width of the per-gate level ports
   localparam int GATES     = 4;
   localparam int MAX_GATES = 4;

   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 7;
   localparam int LIMIT_W = 14;
   localparam int COUNT_W = 16;
   localparam int PHASE_W = 2;
   localparam int QUERY_W = 2;
   localparam int CMD_W   = 2;
   localparam int CSR_W   = 14;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 112;

   localparam logic [LEVEL_W-1:0] OK_LEVEL_RST   = 7'd60;
   localparam logic [LEVEL_W-1:0] WEAK_ENTER_RST = 7'd40;
   localparam logic [LIMIT_W-1:0] SHORT_LIM_RST  = 14'd2000;
   localparam logic [LIMIT_W-1:0] LONG_LIM_RST   = 14'd3000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [PHASE_W-1:0] PH_NORMAL = 2'd0;
   localparam logic [PHASE_W-1:0] PH_WEAK   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_SHORT  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LONG   = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_OK_LEVEL   = 2'd0,
      REG_WEAK_ENTER = 2'd1,
      REG_SHORT_LIM  = 2'd2,
      REG_LONG_LIM   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] ok_level;
      logic [LEVEL_W-1:0] weak_enter;
      logic [LIMIT_W-1:0] short_limit;
      logic [LIMIT_W-1:0] long_limit;
   } cfg_type;

   // Per-step control from the session unit to every gate
   typedef struct packed {
      logic step;
      logic active;
      logic clear_weak;
      logic clear_count;
   } gate_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/weak_beam_event_monitor.sv
// Path: a word accepted on req_ is held in the input register, then one pass of session and
//   gate logic writes the result register that drives rsp_.
// Throughput: one word per cycle; while a finished result waits, the input register takes
//   at most one more word, and both stages advance together when rsp_ is free.
// Reset (synchronous, active high): session stopped, all gate state, counters and
//   totals zero, thresholds back to 60 / 40 percent and 2000 / 3000 ms.
`default_nettype none

module weak_beam_event_monitor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: tdata = now_ms[31:0], live_mask[35:32], level_a[42:36], level_b[49:43],
   //   level_c[56:50], level_d[63:57], query_gate[65:64], zero pad
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [wbem_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request tuser = command[1:0]
   input  wire logic [wbem_pkg::CMD_W-1:0]        req_tuser,
   // response: tdata = phase_a[1:0], phase_b[3:2], phase_c[5:4], phase_d[7:6],
   //   alarm_level[9:8], save_needed[10], session_ms[42:11], short_events[58:43],
   //   long_events[74:59], weak_total_ms[106:75], zero pad
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [wbem_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // configuration writes
   input  wire logic                              csr_we,
   input  wire logic [1:0]                        csr_index,
   input  wire logic [wbem_pkg::CSR_W-1:0]        csr_wdata
);
   import wbem_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ok_level    <= OK_LEVEL_RST;
         cfg_ff.weak_enter  <= WEAK_ENTER_RST;
         cfg_ff.short_limit <= SHORT_LIM_RST;
         cfg_ff.long_limit  <= LONG_LIM_RST;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_index))
            REG_OK_LEVEL:   cfg_ff.ok_level    <= csr_wdata[LEVEL_W-1:0];
            REG_WEAK_ENTER: cfg_ff.weak_enter  <= csr_wdata[LEVEL_W-1:0];
            REG_SHORT_LIM:  cfg_ff.short_limit <= csr_wdata[LIMIT_W-1:0];
            REG_LONG_LIM:   cfg_ff.long_limit  <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Flow control: both stages advance when the result register is
   // empty or being drained; the input register refills in the same edge.
   // ---------------------------------------------------------------
   logic                  advance;
   logic                  step;
   logic                  in_valid_ff, in_valid_in;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic [CMD_W-1:0]      in_cmd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign advance      = !rsp_valid_ff || rsp_tready;
   assign req_tready   = !in_valid_ff || advance;
   assign step         = in_valid_ff && advance;
   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: input loads on handshake, result loads on a step, hold otherwise
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
         in_cmd_ff  <= req_tuser;
      end
      if (step) rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------
   // Unpack the held request word
   // ---------------------------------------------------------------
   logic [TIME_W-1:0]   now_ms;
   logic [MAX_GATES-1:0] live_mask;
   logic [LEVEL_W-1:0]  level_all [MAX_GATES];
   logic [QUERY_W-1:0]  query_gate;

   assign now_ms       = in_data_ff[31:0];
   assign live_mask    = in_data_ff[35:32];
   assign level_all[0] = in_data_ff[42:36];
   assign level_all[1] = in_data_ff[49:43];
   assign level_all[2] = in_data_ff[56:50];
   assign level_all[3] = in_data_ff[63:57];
   assign query_gate   = in_data_ff[65:64];

   // ---------------------------------------------------------------
   // Session timing and command handling
   // ---------------------------------------------------------------
   gate_ctrl_type     gate_ctrl;
   logic [TIME_W-1:0] dt_ms;
   logic [TIME_W-1:0] session_ms;
   logic              cmd_save;

   wbem_session u_session (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .command    (cmd_type'(in_cmd_ff)),
      .now_ms     (now_ms),
      .ctrl       (gate_ctrl),
      .dt_ms      (dt_ms),
      .session_ms (session_ms),
      .cmd_save   (cmd_save)
   );

   // ---------------------------------------------------------------
   // Per-gate weak tracking, all gates in parallel
   // ---------------------------------------------------------------
   logic [PHASE_W-1:0]   phase_all [MAX_GATES];
   logic [MAX_GATES-1:0] event_all;
   logic [COUNT_W-1:0]   short_all [MAX_GATES];
   logic [COUNT_W-1:0]   long_all  [MAX_GATES];
   logic [TIME_W-1:0]    weak_all  [MAX_GATES];

   for (genvar g = 0; g < MAX_GATES; g++) begin : g_gate
      if (g < GATES) begin : g_on
         wbem_gate u_gate (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (gate_ctrl),
            .cfg         (cfg_ff),
            .now_ms      (now_ms),
            .dt_ms       (dt_ms),
            .live        (live_mask[g]),
            .level       (level_all[g]),
            .phase       (phase_all[g]),
            .event_hit   (event_all[g]),
            .short_count (short_all[g]),
            .long_count  (long_all[g]),
            .weak_time   (weak_all[g])
         );
      end else begin : g_off
         assign phase_all[g] = PH_NORMAL;
         assign event_all[g] = 1'b0;
         assign short_all[g] = '0;
         assign long_all[g]  = '0;
         assign weak_all[g]  = '0;
      end
   end

   // ---------------------------------------------------------------
   // Form the result word
   // ---------------------------------------------------------------
   logic [PHASE_W-1:0] alarm_level;
   logic               save_needed;
   logic [COUNT_W-1:0] short_events;
   logic [COUNT_W-1:0] long_events;
   logic [TIME_W-1:0]  weak_total_ms;

   always_comb begin
      alarm_level = PH_NORMAL;
      for (int g = 0; g < MAX_GATES; g++) begin
         if (phase_all[g] > alarm_level) alarm_level = phase_all[g];
      end
      save_needed = cmd_save || (|event_all);
      // drop the counters for a gate that is not fitted
      if (int'(query_gate) < GATES) begin
         short_events  = short_all[query_gate];
         long_events   = long_all[query_gate];
         weak_total_ms = weak_all[query_gate];
      end else begin
         short_events  = '0;
         long_events   = '0;
         weak_total_ms = '0;
      end
      rsp_data_in = '0;
      rsp_data_in[1:0]    = phase_all[0];
      rsp_data_in[3:2]    = phase_all[1];
      rsp_data_in[5:4]    = phase_all[2];
      rsp_data_in[7:6]    = phase_all[3];
      rsp_data_in[9:8]    = alarm_level;
      rsp_data_in[10]     = save_needed;
      rsp_data_in[42:11]  = session_ms;
      rsp_data_in[58:43]  = short_events;
      rsp_data_in[74:59]  = long_events;
      rsp_data_in[106:75] = weak_total_ms;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_step_fills_rsp : assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff) && $stable(in_cmd_ff))
      else $error("held request word changed during a stall");

   a_idle_no_phase : assert property (@(posedge clock) disable iff (reset)
      step && !gate_ctrl.active |=> rsp_data_ff[9:0] == '0)
      else $error("phase reported while session is stopped");

   a_full_reset_saves : assert property (@(posedge clock) disable iff (reset)
      step && cmd_type'(in_cmd_ff) == CMD_RESET |=> rsp_data_ff[10])
      else $error("full reset did not flag a save");

endmodule

`default_nettype wire

>>> rtl/core/wbem_session.sv
`default_nettype none

module wbem_session (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire wbem_pkg::cmd_type             command,
   input  wire logic [wbem_pkg::TIME_W-1:0]   now_ms,
   output wbem_pkg::gate_ctrl_type            ctrl,
   output logic [wbem_pkg::TIME_W-1:0]        dt_ms,
   output logic [wbem_pkg::TIME_W-1:0]        session_ms,
   output logic                               cmd_save
);
   import wbem_pkg::*;

   logic              running_ff, running_in;
   logic [TIME_W-1:0] session_total_ff, session_total_in;
   logic [TIME_W-1:0] segment_start_ff, segment_start_in;
   logic [TIME_W-1:0] last_tick_ff, last_tick_in;
   logic [TIME_W-1:0] seg_diff;
   logic [TIME_W-1:0] seg_sum;
   logic [TIME_W-1:0] last_eff;

   assign seg_diff = now_ms - segment_start_ff;
   assign seg_sum  = session_total_ff + seg_diff;
   // zero stamp means no running tick seen yet
   assign last_eff = (last_tick_ff == '0) ? now_ms : last_tick_ff;

   always_comb begin
      running_in       = running_ff;
      session_total_in = session_total_ff;
      segment_start_in = segment_start_ff;
      ctrl.clear_weak  = 1'b0;
      ctrl.clear_count = 1'b0;
      cmd_save         = 1'b0;
      session_ms       = session_total_ff;
      unique case (command)
         CMD_TICK: begin
            if (running_ff) session_ms = seg_sum;
         end
         CMD_START: begin
            if (!running_ff) begin
               running_in       = 1'b1;
               segment_start_in = now_ms;
               ctrl.clear_weak  = 1'b1;
            end else begin
               session_ms = seg_sum;
            end
         end
         CMD_STOP: begin
            if (running_ff) begin
               running_in       = 1'b0;
               session_total_in = seg_sum;
               session_ms       = seg_sum;
               ctrl.clear_weak  = 1'b1;
            end
         end
         CMD_RESET: begin
            running_in       = 1'b0;
            session_total_in = '0;
            session_ms       = '0;
            ctrl.clear_weak  = 1'b1;
            ctrl.clear_count = 1'b1;
            cmd_save         = 1'b1;
         end
         default: ;
      endcase
      ctrl.step    = step;
      ctrl.active  = running_in;
      // not running: weak state drops as well
      if (!running_in) ctrl.clear_weak = 1'b1;
      dt_ms        = now_ms - last_eff;
      last_tick_in = running_in ? now_ms : last_tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff       <= 1'b0;
         session_total_ff <= '0;
         segment_start_ff <= '0;
         last_tick_ff     <= '0;
      end else if (step) begin
         running_ff       <= running_in;
         session_total_ff <= session_total_in;
         segment_start_ff <= segment_start_in;
         last_tick_ff     <= last_tick_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/wbem_gate.sv
`default_nettype none

module wbem_gate (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wbem_pkg::gate_ctrl_type       ctrl,
   input  wire wbem_pkg::cfg_type             cfg,
   input  wire logic [wbem_pkg::TIME_W-1:0]   now_ms,
   input  wire logic [wbem_pkg::TIME_W-1:0]   dt_ms,
   input  wire logic                          live,
   input  wire logic [wbem_pkg::LEVEL_W-1:0]  level,
   output logic [wbem_pkg::PHASE_W-1:0]       phase,
   output logic                               event_hit,
   output logic [wbem_pkg::COUNT_W-1:0]       short_count,
   output logic [wbem_pkg::COUNT_W-1:0]       long_count,
   output logic [wbem_pkg::TIME_W-1:0]        weak_time
);
   import wbem_pkg::*;

   logic               flag_ff, flag_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic               short_seen_ff, short_seen_in;
   logic               long_seen_ff, long_seen_in;
   logic [COUNT_W-1:0] short_cnt_ff, short_cnt_in;
   logic [COUNT_W-1:0] long_cnt_ff, long_cnt_in;
   logic [TIME_W-1:0]  weak_time_ff, weak_time_in;

   logic               flag_c;
   logic [TIME_W-1:0]  start_c;
   logic               tracking;
   logic [TIME_W-1:0]  weak_ms;
   logic               short_hit;
   logic               long_hit;

   always_comb begin
      flag_c        = ctrl.clear_weak ? 1'b0 : flag_ff;
      start_c       = ctrl.clear_weak ? '0 : start_ff;
      flag_in       = flag_c;
      start_in      = start_c;
      short_seen_in = ctrl.clear_weak ? 1'b0 : short_seen_ff;
      long_seen_in  = ctrl.clear_weak ? 1'b0 : long_seen_ff;
      short_cnt_in  = ctrl.clear_count ? '0 : short_cnt_ff;
      long_cnt_in   = ctrl.clear_count ? '0 : long_cnt_ff;
      weak_time_in  = ctrl.clear_count ? '0 : weak_time_ff;
      tracking      = 1'b0;
      phase         = PH_NORMAL;
      event_hit     = 1'b0;
      weak_ms       = now_ms - start_c;

      if (ctrl.active && live) begin
         if (!flag_c) begin
            if (level <= cfg.weak_enter) begin
               // enter a weak episode now
               tracking      = 1'b1;
               flag_in       = 1'b1;
               start_in      = now_ms;
               short_seen_in = 1'b0;
               long_seen_in  = 1'b0;
               weak_ms       = '0;
            end
         end else if (level >= cfg.ok_level) begin
            flag_in       = 1'b0;
            start_in      = '0;
            short_seen_in = 1'b0;
            long_seen_in  = 1'b0;
         end else begin
            tracking = 1'b1;
         end
      end

      short_hit = weak_ms > TIME_W'(cfg.short_limit);
      long_hit  = weak_ms >= TIME_W'(cfg.long_limit);

      if (tracking) begin
         if (short_hit && !short_seen_in) begin
            short_seen_in = 1'b1;
            event_hit     = 1'b1;
            if (short_cnt_in != COUNT_MAX) short_cnt_in = short_cnt_in + 1'b1;
         end
         if (long_hit && !long_seen_in) begin
            long_seen_in = 1'b1;
            event_hit    = 1'b1;
            if (long_cnt_in != COUNT_MAX) long_cnt_in = long_cnt_in + 1'b1;
         end
         weak_time_in = weak_time_in + dt_ms;
         priority if (long_hit)  phase = PH_LONG;
         else if (short_hit)     phase = PH_SHORT;
         else                    phase = PH_WEAK;
      end
   end

   assign short_count = short_cnt_in;
   assign long_count  = long_cnt_in;
   assign weak_time   = weak_time_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff       <= 1'b0;
         start_ff      <= '0;
         short_seen_ff <= 1'b0;
         long_seen_ff  <= 1'b0;
         short_cnt_ff  <= '0;
         long_cnt_ff   <= '0;
         weak_time_ff  <= '0;
      end else if (ctrl.step) begin
         flag_ff       <= flag_in;
         start_ff      <= start_in;
         short_seen_ff <= short_seen_in;
         long_seen_ff  <= long_seen_in;
         short_cnt_ff  <= short_cnt_in;
         long_cnt_ff   <= long_cnt_in;
         weak_time_ff  <= weak_time_in;
      end
   end

endmodule

`default_nettype wire
